/* hdl/int8_dot_product_dequantizer_core_defines.svh */
// ----------------------------------------------------------------------------
// int8_dot_product_dequantizer_core_defines
// assertion macros used by the checker of the dot product core
// ----------------------------------------------------------------------------
`ifndef INT8_DOT_PRODUCT_DEQUANTIZER_CORE_DEFINES_SVH
`define INT8_DOT_PRODUCT_DEQUANTIZER_CORE_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define IDPD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define IDPD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/idpd_pkg.sv */
// ----------------------------------------------------------------------------
// idpd_pkg
// shared types and constants of the int8 dot product dequantizer core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package idpd_pkg;

	// field and datapath widths
	localparam int APB_ADDR_W = 5;
	localparam int ACC_W      = 40;
	localparam int RES_W      = 48;
	localparam int PROD_W     = 104;

	// iteration counts of the divider and the multiplier
	localparam int DIV_STEPS = 64;
	localparam int MUL_STEPS = 4;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	// register indexes
	localparam logic [2:0] REG_CHAN_MODE   = 3'd0;
	localparam logic [2:0] REG_ZP_PRESENT  = 3'd1;
	localparam logic [2:0] REG_BIAS_EN     = 3'd2;
	localparam logic [2:0] REG_ACT_ZP      = 3'd3;
	localparam logic [2:0] REG_WT_ZP       = 3'd4;
	localparam logic [2:0] REG_ACT_SCALE   = 3'd5;
	localparam logic [2:0] REG_WT_SCALE    = 3'd6;
	localparam logic [2:0] REG_OUT_SCALE   = 3'd7;

	// fixed point constants
	localparam logic [31:0]      ONE_Q24  = 32'h0100_0000;
	localparam logic [ACC_W-1:0] ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic [ACC_W-1:0] ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic [RES_W-1:0] RES_MAX  = {1'b0, {(RES_W-1){1'b1}}};
	localparam logic [RES_W-1:0] RES_MIN  = {1'b1, {(RES_W-1){1'b0}}};
	localparam logic [7:0]       ROUND_HALF = 8'h80;

	// configuration register file contents
	typedef struct packed {
		logic        chan_mode;
		logic        zp_present;
		logic        bias_en;
		logic [7:0]  act_zp;
		logic [7:0]  wt_zp;
		logic [31:0] act_scale;
		logic [31:0] wt_scale;
		logic [31:0] out_scale;
	} cfg_t;

	// controller to datapath commands
	typedef struct packed {
		logic acc_en;
		logic start;
		logic div_step;
		logic mul_step;
		logic rnd;
		logic out_load;
	} ctrl_cmd_t;

	// controller states
	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_PROD = 6'b000010,
		ST_DIV  = 6'b000100,
		ST_MUL  = 6'b001000,
		ST_RND  = 6'b010000,
		ST_BIAS = 6'b100000
	} state_t;

endpackage

`default_nettype wire

/* hdl/int8_dot_product_dequantizer_core.sv */
// ----------------------------------------------------------------------------
// int8_dot_product_dequantizer_core
// Takes one int8 activation/weight pair per transfer and accumulates the
// zero-point corrected products in a clamping 40-bit accumulator; transfers
// without last are taken back to back. The transfer flagged last ends the
// row: the sum is scaled by act_scale * (wt_scale or chan_wt_scale) /
// out_scale (Q8.24, out_scale 0 reads as 1.0), rounded to Q.16, optionally
// biased and delivered as one saturated 48-bit result. The scale divider
// resolves one quotient bit per cycle and the multiplier handles sixteen
// quotient bits per cycle; after the last transfer the core runs scale
// product, divide, multiply, round and bias, taking no input; a result
// waiting on out_ready does not stall the next row until its last transfer.
// Configuration sits on an APB port at byte address 4*index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module int8_dot_product_dequantizer_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [idpd_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [7:0]                activation,
	input  logic signed [7:0]                weight,
	input  logic signed [7:0]                chan_wt_zero_point,
	input  logic [31:0]                      chan_wt_scale,
	input  logic signed [31:0]               bias,
	input  logic                             last,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [idpd_pkg::RES_W-1:0] result,
	output logic                             saturated
);
	import idpd_pkg::*;

	cfg_t      cfg;
	ctrl_cmd_t cmd;

	// configuration registers
	idpd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer
	idpd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// arithmetic
	idpd_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.cfg                (cfg),
		.activation         (activation),
		.weight             (weight),
		.chan_wt_zero_point (chan_wt_zero_point),
		.chan_wt_scale      (chan_wt_scale),
		.bias               (bias),
		.result             (result),
		.saturated          (saturated)
	);

endmodule

`default_nettype wire

/* hdl/idpd_regs.sv */
// ----------------------------------------------------------------------------
// idpd_regs
// apb configuration register file, one register per 32-bit word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module idpd_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [idpd_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	output idpd_pkg::cfg_t                   cfg
);
	import idpd_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = paddr[APB_ADDR_W-1:2];
	assign cfg    = cfg_q;

	// register writes on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.chan_mode   <= 1'b0;
			cfg_q.zp_present  <= 1'b0;
			cfg_q.bias_en     <= 1'b0;
			cfg_q.act_zp      <= 8'd0;
			cfg_q.wt_zp       <= 8'd0;
			cfg_q.act_scale   <= ONE_Q24;
			cfg_q.wt_scale    <= ONE_Q24;
			cfg_q.out_scale   <= ONE_Q24;
		end else if (wr_en) begin
			unique case (idx)
				REG_CHAN_MODE:   cfg_q.chan_mode   <= pwdata[0];
				REG_ZP_PRESENT:  cfg_q.zp_present  <= pwdata[0];
				REG_BIAS_EN:     cfg_q.bias_en     <= pwdata[0];
				REG_ACT_ZP:      cfg_q.act_zp      <= pwdata[7:0];
				REG_WT_ZP:       cfg_q.wt_zp       <= pwdata[7:0];
				REG_ACT_SCALE:   cfg_q.act_scale   <= pwdata;
				REG_WT_SCALE:    cfg_q.wt_scale    <= pwdata;
				REG_OUT_SCALE:   cfg_q.out_scale   <= pwdata;
				default:         cfg_q.chan_mode   <= cfg_q.chan_mode;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (idx)
			REG_CHAN_MODE:   prdata = {31'd0, cfg_q.chan_mode};
			REG_ZP_PRESENT:  prdata = {31'd0, cfg_q.zp_present};
			REG_BIAS_EN:     prdata = {31'd0, cfg_q.bias_en};
			REG_ACT_ZP:      prdata = {24'd0, cfg_q.act_zp};
			REG_WT_ZP:       prdata = {24'd0, cfg_q.wt_zp};
			REG_ACT_SCALE:   prdata = cfg_q.act_scale;
			REG_WT_SCALE:    prdata = cfg_q.wt_scale;
			REG_OUT_SCALE:   prdata = cfg_q.out_scale;
			default:         prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

/* hdl/idpd_ctrl.sv */
// ----------------------------------------------------------------------------
// idpd_ctrl
// sequencer: accumulate, scale product, divide, multiply, round, bias
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module idpd_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  last,
	output logic                  out_valid,
	input  logic                  out_ready,
	output idpd_pkg::ctrl_cmd_t   cmd
);
	import idpd_pkg::*;

	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);
	localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_STEPS - 1);

	state_t           state_q;
	state_t           state_nxt;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	// commands and next state
	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.acc_en = in_valid;
				if (in_valid && last) begin
					state_nxt = ST_PROD;
				end
			end
			ST_PROD: begin
				cmd.start = 1'b1;
				state_nxt = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == DIV_LAST) begin
					state_nxt = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul_step = 1'b1;
				if (cnt_q == MUL_LAST) begin
					state_nxt = ST_RND;
				end
			end
			ST_RND: begin
				cmd.rnd   = 1'b1;
				state_nxt = ST_BIAS;
			end
			ST_BIAS: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// state, step counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q != state_nxt) begin
				cnt_q <= '0;
			end else if (cmd.div_step || cmd.mul_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/idpd_dp.sv */
// ----------------------------------------------------------------------------
// idpd_dp
// datapath: saturating accumulator, restoring divider, shift-add multiplier
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module idpd_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  idpd_pkg::ctrl_cmd_t           cmd,
	input  idpd_pkg::cfg_t                cfg,
	input  logic signed [7:0]             activation,
	input  logic signed [7:0]             weight,
	input  logic signed [7:0]             chan_wt_zero_point,
	input  logic [31:0]                   chan_wt_scale,
	input  logic signed [31:0]            bias,
	output logic signed [idpd_pkg::RES_W-1:0] result,
	output logic                          saturated
);
	import idpd_pkg::*;

	// accumulate path
	logic [7:0]         wzp;
	logic signed [8:0]  a_off;
	logic signed [8:0]  w_off;
	logic signed [17:0] pair_prod;
	logic [ACC_W:0]     acc_sum;
	logic [ACC_W-1:0]   acc_q;
	logic               ovf_q;

	// items captured from the last transfer of a row
	logic [31:0]        cscale_q;
	logic [31:0]        bias_q;

	// final scaling path
	logic [31:0]        ws;
	logic [31:0]        os_eff;
	logic [63:0]        scale_prod;
	logic [63:0]        num_q;
	logic [31:0]        rem_q;
	logic [32:0]        rem_sh;
	logic [32:0]        rem_sub;
	logic               rem_ge;
	logic [ACC_W-1:0]   mag_q;
	logic               neg_q;
	logic [55:0]        part_prod;
	logic [PROD_W-1:0]  prod_q;
	logic [PROD_W:0]    prod_rnd;
	logic [PROD_W-8:0]  prod_q16;
	logic [RES_W-1:0]   lim;
	logic               rnd_over;
	logic [RES_W-1:0]   val_q;
	logic               sat_q;
	logic [RES_W:0]     bias_sum;
	logic [RES_W:0]     bias_ext;

	// weight zero point select and offset products
	always_comb begin
		if (cfg.chan_mode) begin
			wzp = cfg.zp_present ? chan_wt_zero_point : 8'd0;
		end else begin
			wzp = cfg.wt_zp;
		end
	end

	assign a_off     = $signed({activation[7], activation}) - $signed({cfg.act_zp[7], cfg.act_zp});
	assign w_off     = $signed({weight[7], weight}) - $signed({wzp[7], wzp});
	assign pair_prod = a_off * w_off;
	assign acc_sum   = {acc_q[ACC_W-1], acc_q}
		+ {{(ACC_W + 1 - 18){pair_prod[17]}}, pair_prod};

	// accumulator with clamp, cleared when the row is handed to scaling
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.acc_en) begin
			if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
				acc_q <= acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
				ovf_q <= 1'b1;
			end else begin
				acc_q <= acc_sum[ACC_W-1:0];
			end
		end else if (cmd.start) begin
			acc_q <= '0;
			ovf_q <= 1'b0;
		end
	end

	// per-row fields, the last transfer's values stay
	always_ff @(posedge clk) begin
		if (cmd.acc_en) begin
			cscale_q <= chan_wt_scale;
			bias_q   <= bias;
		end
	end

	// combined scale: act_scale * weight scale, divided by out_scale
	assign ws         = cfg.chan_mode ? cscale_q : cfg.wt_scale;
	assign os_eff     = (cfg.out_scale == 32'd0) ? ONE_Q24 : cfg.out_scale;
	assign scale_prod = cfg.act_scale * ws;

	// restoring divider step, quotient bits shift into num_q
	assign rem_sh  = {rem_q, num_q[63]};
	assign rem_sub = rem_sh - {1'b0, os_eff};
	assign rem_ge  = (rem_sh >= {1'b0, os_eff});

	// magnitude times quotient, sixteen quotient bits per step from the top
	assign part_prod = mag_q * num_q[63:48];

	// round half away from zero to q.16 and limit by sign
	assign prod_rnd = {1'b0, prod_q} + {{(PROD_W + 1 - 8){1'b0}}, ROUND_HALF};
	assign prod_q16 = prod_rnd[PROD_W:8];
	assign lim      = neg_q ? RES_MIN : RES_MAX;
	assign rnd_over = (prod_q16 > {{(PROD_W - 7 - RES_W){1'b0}}, lim});

	// optional bias
	assign bias_ext = cfg.bias_en ? {{(RES_W + 1 - 32){bias_q[31]}}, bias_q} : '0;
	assign bias_sum = {val_q[RES_W-1], val_q} + bias_ext;

	// scaling sequence registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			num_q  <= scale_prod;
			rem_q  <= '0;
			prod_q <= '0;
			neg_q  <= acc_q[ACC_W-1];
			mag_q  <= acc_q[ACC_W-1] ? (ACC_W'(0) - acc_q) : acc_q;
			sat_q  <= ovf_q;
		end else if (cmd.div_step) begin
			rem_q <= rem_ge ? rem_sub[31:0] : rem_sh[31:0];
			num_q <= {num_q[62:0], rem_ge};
		end else if (cmd.mul_step) begin
			prod_q <= {prod_q[PROD_W-17:0], 16'd0} + {{(PROD_W - 56){1'b0}}, part_prod};
			num_q  <= {num_q[47:0], 16'd0};
		end else if (cmd.rnd) begin
			if (rnd_over) begin
				val_q <= lim;
				sat_q <= 1'b1;
			end else begin
				val_q <= neg_q ? (RES_W'(0) - prod_q16[RES_W-1:0]) : prod_q16[RES_W-1:0];
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (bias_sum[RES_W] != bias_sum[RES_W-1]) begin
				result    <= bias_sum[RES_W] ? RES_MIN : RES_MAX;
				saturated <= 1'b1;
			end else begin
				result    <= bias_sum[RES_W-1:0];
				saturated <= sat_q;
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/idpd_checker.sv */
// ----------------------------------------------------------------------------
// idpd_checker
// port-level checks of the dot product core, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "int8_dot_product_dequantizer_core_defines.svh"

module idpd_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic                              last,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic signed [idpd_pkg::RES_W-1:0] result,
	input  logic                              saturated
);

	// a stalled result holds
	`IDPD_ASSERT_NEXT(a_out_hold, (out_valid && !out_ready), (out_valid && $stable(result) && $stable(saturated)), "result changed while stalled")

	// the last transfer of a row starts the scaling sequence, input closes
	`IDPD_ASSERT_NEXT(a_last_busy, (in_valid && in_ready && last), (!in_ready), "input open after last transfer")

	// a new result only comes out of the scaling sequence
	`IDPD_ASSERT_SAME(a_out_from_busy, $rose(out_valid), (!$past(in_ready)), "result without scaling sequence")

endmodule

bind int8_dot_product_dequantizer_core idpd_checker u_idpd_checker (.*);

`default_nettype wire
